/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the frame receiver RTL.
// Every check is sampled on the rising edge of clk_i and is switched off
// while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check.
`define SFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sfcrc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfcrc_pkg
// Types, constants and the CRC-8 byte update that the frame receiver uses.
// ---------------------------------------------------------------------------
package sfcrc_pkg;

  localparam logic [7:0] SOF_BYTE = 8'd73;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Receiver phase. Codes six and seven are unused and act as hunting.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_e;

  // Kind of a reported result.
  typedef enum logic [2:0] {
    K_TYPE    = 3'd0,
    K_LENGTH  = 3'd1,
    K_PAYLOAD = 3'd2,
    K_END     = 3'd3,
    K_DROP    = 3'd4
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic        status;
  } result_t;

  // Handshake between the parser and the output buffer.
  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  // CRC-8, polynomial 0x31, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/sfcrc_in_reg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfcrc_in_reg
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module sfcrc_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       accept;

  // The register is free when it is empty or is emptied in this cycle.
  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign vld_d      = accept | (vld_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

/* hw/rtl/sfcrc_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfcrc_parser
// Frame state machine and running CRC; one byte is handled per cycle while space_i is high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfcrc_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [7:0]      byte_i,
  input  logic            space_i,
  output logic            take_o,
  output sfcrc_pkg::push_t push_o
);
  import sfcrc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  crc_upd;
  logic [15:0] len;
  push_t       push;

  assign take_o  = vld_i & space_i;
  assign crc_upd = crc8_byte(crc_q, byte_i);
  assign len     = {len_hi_q, byte_i};

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d         = phase_q;
    len_hi_d        = len_hi_q;
    rem_d           = rem_q;
    crc_d           = crc_q;
    push.push       = 1'b0;
    push.res.kind   = K_DROP;
    push.res.value  = {8'd0, byte_i};
    push.res.status = 1'b0;
    if (take_o) begin
      unique case (phase_q)
        PH_TYPE: begin
          crc_d         = crc_upd;
          phase_d       = PH_LEN_HI;
          push.push     = 1'b1;
          push.res.kind = K_TYPE;
        end
        PH_LEN_HI: begin
          crc_d    = crc_upd;
          len_hi_d = byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          crc_d          = crc_upd;
          rem_d          = len;
          phase_d        = (len != 16'd0) ? PH_PAYLOAD : PH_CRC;
          push.push      = 1'b1;
          push.res.kind  = K_LENGTH;
          push.res.value = len;
        end
        PH_PAYLOAD: begin
          crc_d         = crc_upd;
          rem_d         = rem_q - 16'd1;
          if (rem_d == 16'd0) begin
            phase_d = PH_CRC;
          end
          push.push     = 1'b1;
          push.res.kind = K_PAYLOAD;
        end
        PH_CRC: begin
          phase_d         = PH_HUNT;
          crc_d           = CRC_INIT;
          push.push       = 1'b1;
          push.res.kind   = K_END;
          push.res.value  = 16'd0;
          push.res.status = (byte_i != crc_q);
        end
        default: begin
          // Hunting, and the unused phase codes.
          if (byte_i == SOF_BYTE) begin
            crc_d   = CRC_INIT;
            phase_d = PH_TYPE;
          end else begin
            phase_d   = PH_HUNT;
            push.push = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      len_hi_q <= 8'd0;
      rem_q    <= 16'd0;
      crc_q    <= CRC_INIT;
    end else begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      rem_q    <= rem_d;
      crc_q    <= crc_d;
    end
  end

  assign push_o = push;

  // A frame in its payload always has bytes left to come.
  `SFC_ASSERT(a_payload_rem, (phase_q != PH_PAYLOAD) || (rem_q != 16'd0), "payload with no bytes left")
  // The CRC byte returns the receiver to hunting with a fresh CRC.
  `SFC_ASSERT_NEXT(a_crc_end, take_o && (phase_q == PH_CRC), (phase_q == PH_HUNT) && (crc_q == CRC_INIT), "frame end did not restart hunting")

endmodule

/* hw/rtl/sfcrc_out_buf.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfcrc_out_buf
// Two-entry result buffer that decouples the parser from output stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfcrc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfcrc_pkg::push_t push_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      value_o,
  output logic             status_o
);
  import sfcrc_pkg::*;

  result_t    ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  result_t    head;

  // Space is judged from the registered count only.
  assign space_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o & ~out_stall_i;

  assign wr_d  = wr_q ^ push_i.push;
  assign rd_d  = rd_q ^ pop;
  assign cnt_d = cnt_q + {1'b0, push_i.push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      ent_q[wr_q] <= push_i.res;
    end
  end

  assign head     = ent_q[rd_q];
  assign kind_o   = head.kind;
  assign value_o  = head.value;
  assign status_o = head.status;

  // The buffer never holds more than two results.
  `SFC_ASSERT(a_cnt_max, cnt_q <= 2'd2, "result buffer count out of range")
  // The parser only writes when there is room.
  `SFC_ASSERT(a_no_overflow, !push_i.push || (cnt_q != 2'd2), "result buffer overflow")

endmodule

/* hw/rtl/sof_length_crc8_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sof_length_crc8_frame_receiver_top
// Start-of-frame / type / length / CRC-8 frame receiver.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_stall_o, rx_byte_i) carries one received
// byte per transfer. The output channel (out_valid_o, out_stall_i, kind_o,
// value_o, status_o) carries at most one result per byte: type, length,
// payload byte, end of frame with CRC status, or a dropped byte seen while
// hunting for the start byte. The start byte and the high length byte give
// no result.
// A byte sits in the input register while the parser works on it, and the
// result is written straight into the output buffer, which offers it.
// Throughput is one byte per cycle while the output buffer has space, set
// by the CRC-8 byte update, which is combinational, and the frame state
// register.
// Reset clears the phase to hunting, the CRC to 0xFF and empties both the
// input register and the two-entry output buffer.
// When the output stalls, results fill the output buffer; once it is full
// the parser holds its byte and in_stall_o rises. It falls again in the cycle
// after a result has been transferred out.
// ---------------------------------------------------------------------------
module sof_length_crc8_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [15:0] value_o,
  output logic        status_o
);
  import sfcrc_pkg::*;

  logic       take;
  logic       in_vld;
  logic [7:0] in_byte;
  logic       space;
  push_t      push;

  sfcrc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  sfcrc_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_vld),
    .byte_i  (in_byte),
    .space_i (space),
    .take_o  (take),
    .push_o  (push)
  );

  sfcrc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame receiver testbench
// Feeds the frame receiver with stray bytes and start / type / length /
// payload / CRC-8 frames, both well formed and with a corrupted CRC byte.
// A scoreboard tracks the receiver's phase and CRC, predicts every report and
// compares each output transfer with the oldest report still awaited. Both
// channels idle in random bursts, and the final stretch runs without idling.
// ---------------------------------------------------------------------------
import sfcrc_pkg::*;

typedef logic [7:0] octet_q_t[$];

// CRC-8 over one byte, polynomial 0x31, most significant bit first.
function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
  logic [7:0] c;
  c = acc ^ data;
  repeat (8) begin
    if (c[7]) begin
      c = {c[6:0], 1'b0} ^ CRC_POLY;
    end else begin
      c = {c[6:0], 1'b0};
    end
  end
  return c;
endfunction

// Tracks the receiver state and holds the reports not yet seen on the output.
class frame_scoreboard;
  phase_e      phase;
  logic [7:0]  len_high;
  logic [15:0] remaining;
  logic [7:0]  crc;
  result_t     awaited_reports[$];
  int          errors;
  int          bytes_in;
  int          frames_ok;
  int          frames_bad;
  int          dropped;

  function new();
    phase     = PH_HUNT;
    len_high  = '0;
    remaining = '0;
    crc       = CRC_INIT;
    errors    = 0;
    bytes_in  = 0;
    frames_ok = 0;
    frames_bad = 0;
    dropped   = 0;
  endfunction

  // Advances the predicted state by one byte taken in, queueing any report.
  function void note_rx_byte(logic [7:0] data);
    result_t rep;
    bit      has_rep;
    has_rep    = 1'b0;
    rep.kind   = K_TYPE;
    rep.value  = '0;
    rep.status = 1'b0;
    bytes_in++;
    case (phase)
      PH_TYPE: begin
        crc       = crc8_step(crc, data);
        phase     = PH_LEN_HI;
        rep.kind  = K_TYPE;
        rep.value = {8'd0, data};
        has_rep   = 1'b1;
      end
      PH_LEN_HI: begin
        crc      = crc8_step(crc, data);
        len_high = data;
        phase    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        crc       = crc8_step(crc, data);
        remaining = {len_high, data};
        // A zero length goes straight on to the CRC byte.
        phase     = (remaining != 16'd0) ? PH_PAYLOAD : PH_CRC;
        rep.kind  = K_LENGTH;
        rep.value = remaining;
        has_rep   = 1'b1;
      end
      PH_PAYLOAD: begin
        crc       = crc8_step(crc, data);
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          phase = PH_CRC;
        end
        rep.kind  = K_PAYLOAD;
        rep.value = {8'd0, data};
        has_rep   = 1'b1;
      end
      PH_CRC: begin
        rep.kind   = K_END;
        rep.status = (data != crc);
        if (rep.status) begin
          frames_bad++;
        end else begin
          frames_ok++;
        end
        phase   = PH_HUNT;
        crc     = CRC_INIT;
        has_rep = 1'b1;
      end
      default: begin
        if (data == SOF_BYTE) begin
          crc   = CRC_INIT;
          phase = PH_TYPE;
        end else begin
          phase     = PH_HUNT;
          rep.kind  = K_DROP;
          rep.value = {8'd0, data};
          has_rep   = 1'b1;
          dropped++;
        end
      end
    endcase
    if (has_rep) begin
      awaited_reports.push_back(rep);
    end
  endfunction

  // Compares one output transfer with the oldest awaited report.
  function void check_result(logic [2:0] kind, logic [15:0] value, logic status);
    result_t exp;
    if (awaited_reports.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d value %0h status %0b",
               $time, kind, value, status);
      errors++;
      return;
    end
    exp = awaited_reports.pop_front();
    if (kind !== exp.kind) begin
      $display("%0t: kind: expected %0d, actual %0d", $time, exp.kind, kind);
      errors++;
    end
    if (value !== exp.value) begin
      $display("%0t: value: expected %0h, actual %0h", $time, exp.value, value);
      errors++;
    end
    if (status !== exp.status) begin
      $display("%0t: status: expected %0b, actual %0b", $time, exp.status, status);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int RANDOM_BYTES = 650;
  localparam int CALM_BYTES   = 200;
  localparam int MODE_SPAN    = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_LENGTH  = 511;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [15:0] value;
  logic        status;

  frame_scoreboard sb;
  bit in_idle_on  = 1'b0;
  bit out_idle_on = 1'b0;
  int sent_count  = 0;
  int quiet_cycles = 0;

  sof_length_crc8_frame_receiver_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .value_o     (value),
    .status_o    (status)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    sb = new();
  end

  // Observes both channels and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        sb.note_rx_byte(rx_byte);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(kind, value, status);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Output back-pressure in random bursts.
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one byte, possibly after an idle gap, and waits for its transfer.
  task automatic offer_byte(input logic [7:0] data);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= data;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent_count++;
  endtask

  // Sends a whole frame; a corrupted frame carries a wrong CRC byte.
  task automatic send_frame(input logic [7:0] ftype, input octet_q_t body, input bit corrupt);
    logic [7:0]  c;
    logic [15:0] n;
    n = 16'(body.size());
    c = CRC_INIT;
    offer_byte(SOF_BYTE);
    offer_byte(ftype);
    c = crc8_step(c, ftype);
    offer_byte(n[15:8]);
    c = crc8_step(c, n[15:8]);
    offer_byte(n[7:0]);
    c = crc8_step(c, n[7:0]);
    foreach (body[i]) begin
      offer_byte(body[i]);
      c = crc8_step(c, body[i]);
    end
    if (corrupt) begin
      c = c ^ 8'($urandom_range(1, 255));
    end
    offer_byte(c);
  endtask

  function automatic octet_q_t random_body(int n);
    octet_q_t q;
    for (int i = 0; i < n; i++) begin
      q.push_back(8'($urandom));
    end
    return q;
  endfunction

  // Sends a burst of stray bytes, never the start byte.
  task automatic send_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do begin
        b = 8'($urandom);
      end while (b == SOF_BYTE);
      offer_byte(b);
    end
  endtask

  initial begin
    int base;
    int next_mode_at;
    int pick;
    int n;
    int mode;
    octet_q_t body;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: stray bytes around the start value, zero length,
    // a start byte inside the payload, byte extremes and a bad CRC.
    offer_byte(8'h00);
    offer_byte(8'hFF);
    offer_byte(SOF_BYTE - 8'd1);
    offer_byte(SOF_BYTE + 8'd1);
    body = {};
    send_frame(8'h00, body, 1'b0);
    body = {SOF_BYTE};
    send_frame(8'hFF, body, 1'b0);
    body = {8'h00, 8'hFF};
    send_frame(SOF_BYTE, body, 1'b1);

    // One long frame whose length uses both length bytes, with idling on
    // both sides.
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_frame(8'($urandom), random_body(LONG_LENGTH), 1'b0);

    // Random part: mostly well-formed frames with small lengths, some with a
    // bad CRC, and bursts of stray bytes. Idling changes every span and stops
    // for the final stretch.
    base = sent_count;
    next_mode_at = base;
    while (sent_count - base < RANDOM_BYTES) begin
      if (sent_count - base >= RANDOM_BYTES - CALM_BYTES) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else if (sent_count >= next_mode_at) begin
        mode = $urandom_range(0, 3);
        in_idle_on   = mode[0];
        out_idle_on  = mode[1];
        next_mode_at = sent_count + MODE_SPAN;
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        n = $urandom_range(0, 99);
        if (n < 80) begin
          n = $urandom_range(0, 8);
        end else if (n < 95) begin
          n = $urandom_range(9, 64);
        end else begin
          n = $urandom_range(65, 300);
        end
        send_frame(8'($urandom), random_body(n), pick >= 70);
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
    in_valid <= 1'b0;

    // Let every awaited report arrive, then keep watching the output for stray results.
    while (sb.awaited_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes: %0d frames with a good CRC, %0d with a bad CRC,",
             sb.bytes_in, sb.frames_ok, sb.frames_bad);
    $display("and %0d stray bytes dropped while hunting.", sb.dropped);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
